// ----- sv/fir45_pkg.sv -----
`default_nettype none
package fir45_pkg;

	// Word and filter sizes
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int TAPS     = 45;

	// Symmetric taps: the outer pairs share one coefficient, and the center tap stands alone
	localparam int NPROD  = (TAPS + 1) / 2;
	localparam int PRE_W  = SAMPLE_W + 1;
	localparam int PROD_W = PRE_W + COEF_W;

	// Sum of |coef| is below 2^17, so the exact sum fits in 34 bits; 36 leaves margin
	localparam int ACC_W  = 36;
	localparam int CFRAC  = COEF_W - 2;
	localparam int Q_W    = ACC_W - CFRAC;

	// Adder tree: groups of four, then groups of three, then the last pair
	localparam int GRP3   = 4;
	localparam int NSUM3  = (NPROD + GRP3 - 1) / GRP3;
	localparam int GRP4   = 3;
	localparam int NSUM4  = (NSUM3 + GRP4 - 1) / GRP4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PRE_W-1:0]    pre_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [Q_W-1:0]      quot_t;

	// Output clipping limits, in the width of the rounded sum
	localparam quot_t Q_MAX = quot_t'((2 ** (SAMPLE_W - 1)) - 1);
	localparam quot_t Q_MIN = quot_t'(-(2 ** (SAMPLE_W - 1)));
	localparam acc_t  RND_HALF = acc_t'(2 ** (CFRAC - 1));

	// Q2.14 coefficients, taps 0 to 22 (taps 23 to 44 mirror them)
	localparam coef_t COEF [NPROD] = '{
		-16'sd104,  -16'sd437,  -16'sd576,  -16'sd12,   16'sd432,   -16'sd161,
		-16'sd446,  16'sd449,   16'sd362,   -16'sd818,  -16'sd45,   16'sd1160,
		-16'sd598,  -16'sd1274, 16'sd1580,  16'sd889,   -16'sd2815, 16'sd339,
		16'sd4204,  -16'sd3068, -16'sd6193, 16'sd10655, 16'sd23843
	};

endpackage
`default_nettype wire

// ----- sv/fir_filter_45_tap_fixed.sv -----
// 45-tap symmetric FIR filter, Q1.15 samples in and out, fixed Q2.14 coefficients.
// Input channel: in_valid / in_stall with sample_in. A word is taken at a rising
// edge where in_valid is high and in_stall is low. Each taken word shifts into
// the delay line and yields exactly one result word.
// Output channel: out_valid / out_stall with sample_out and saturated. The result
// is the sum of the taps rounded to Q1.15 and clipped. saturated flags the clipping.
// Pipeline: pre-add of mirrored taps, constant multiply, three adder levels, and an
// output stage that rounds and clips.
// Throughput: one word per cycle while out_stall stays low. Each stage holds its
// word only while the stage after it is full and held. Bubbles close up, so a
// stalled receiver lets up to six words collect before in_stall rises. The
// stall path is one enable chain through the six stages.
// Reset (arst_n low): the delay line clears to zeros and all pipeline stages empty.
`default_nettype none
module fir_filter_45_tap_fixed import fir45_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire sample_t sample_in,
	output logic         out_valid,
	input  wire logic    out_stall,
	output sample_t      sample_out,
	output logic         saturated
);

	sample_t dl_q [TAPS];
	sample_t nd [TAPS];
	pre_t    pre_c [NPROD];
	pre_t    pre_s1 [NPROD];
	prod_t   prod_s2 [NPROD];
	acc_t    sum_c3 [NSUM3];
	acc_t    sum_s3 [NSUM3];
	acc_t    sum_c4 [NSUM4];
	acc_t    sum_s4 [NSUM4];
	acc_t    sum_c5;
	acc_t    sum_s5;
	acc_t    rnd;
	quot_t   quot;
	logic    v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, out_v_q;
	logic    en1, en2, en3, en4, en5, en_o;
	logic    take;

	// Enable chain: a stage moves when it is empty or the next one moves
	assign en_o     = !out_v_q || !out_stall;
	assign en5      = !v5_s5 || en_o;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_stall = !en1;
	assign take     = in_valid && en1;

	// Delay line after the shift, newest word at the top
	always_comb begin
		for (int k = 0; k < TAPS - 1; k++) begin
			nd[k] = dl_q[k + 1];
		end
		nd[TAPS - 1] = sample_in;
	end

	// Pre-add mirrored taps
	always_comb begin
		for (int i = 0; i < NPROD - 1; i++) begin
			pre_c[i] = pre_t'(nd[i]) + pre_t'(nd[TAPS - 1 - i]);
		end
		pre_c[NPROD - 1] = pre_t'(nd[NPROD - 1]);
	end

	// First adder level: groups of four products
	always_comb begin
		for (int g = 0; g < NSUM3; g++) begin
			sum_c3[g] = '0;
			for (int j = 0; j < GRP3; j++) begin
				if (g * GRP3 + j < NPROD) begin
					sum_c3[g] = sum_c3[g] + acc_t'(prod_s2[g * GRP3 + j]);
				end
			end
		end
	end

	// Second adder level: groups of three partial sums
	always_comb begin
		for (int g = 0; g < NSUM4; g++) begin
			sum_c4[g] = '0;
			for (int j = 0; j < GRP4; j++) begin
				if (g * GRP4 + j < NSUM3) begin
					sum_c4[g] = sum_c4[g] + sum_s3[g * GRP4 + j];
				end
			end
		end
	end

	// Final add
	always_comb begin
		sum_c5 = '0;
		for (int g = 0; g < NSUM4; g++) begin
			sum_c5 = sum_c5 + sum_s4[g];
		end
	end

	// Round half up to Q1.15
	assign rnd  = sum_s5 + RND_HALF;
	assign quot = rnd[ACC_W-1:CFRAC];

	// Delay line, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				dl_q[k] <= '0;
			end
		end else if (take) begin
			dl_q <= nd;
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			v5_s5   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) v1_s1   <= take;
			if (en2) v2_s2   <= v1_s1;
			if (en3) v3_s3   <= v2_s2;
			if (en4) v4_s4   <= v3_s3;
			if (en5) v5_s5   <= v4_s4;
			if (en_o) out_v_q <= v5_s5;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en1) pre_s1 <= pre_c;
		if (en2) begin
			for (int i = 0; i < NPROD; i++) begin
				prod_s2[i] <= prod_t'(pre_s1[i]) * prod_t'(COEF[i]);
			end
		end
		if (en3) sum_s3 <= sum_c3;
		if (en4) sum_s4 <= sum_c4;
		if (en5) sum_s5 <= sum_c5;
		if (en_o) begin
			if (quot > Q_MAX) begin
				sample_out <= sample_t'(Q_MAX);
				saturated  <= 1'b1;
			end else if (quot < Q_MIN) begin
				sample_out <= sample_t'(Q_MIN);
				saturated  <= 1'b1;
			end else begin
				sample_out <= quot[SAMPLE_W-1:0];
				saturated  <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;

endmodule
`default_nettype wire

// ----- sv/fir45_checker.sv -----
`default_nettype none
module fir45_checker import fir45_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_stall,
	input wire logic    out_valid,
	input wire logic    out_stall,
	input wire sample_t sample_out,
	input wire logic    saturated
);

	// No result word while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// Input backs up only when the output is full and held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held result word");

	// A held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(saturated))
		else $error("result word changed while stalled");

	// Clipping only ever lands on the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(sample_out == sample_t'(Q_MAX)) || (sample_out == sample_t'(Q_MIN)))
		else $error("saturated word not at a range limit");

endmodule

bind fir_filter_45_tap_fixed fir45_checker u_fir45_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.sample_out (sample_out),
	.saturated  (saturated)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
	import fir45_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLDOFF_AT  = 300;   // accepted words before the long receiver hold-off
	localparam int HOLDOFF_LEN = 250;
	localparam int DRAIN_AT    = 900;   // accepted words before the sender waits for a drain
	localparam int N_RANDOM    = 1550;
	localparam int SETTLE      = 20;

	typedef struct packed {
		sample_t value;
		logic    clipped;
	} filt_word_t;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	sample_t sample_in;
	logic    out_valid;
	logic    out_stall;
	sample_t sample_out;
	logic    saturated;

	// Q2.14 taps 0..22; taps 23..44 mirror them
	int half_coef [23] = '{
		-104, -437, -576, -12, 432, -161, -446, 449, 362, -818, -45, 1160,
		-598, -1274, 1580, 889, -2815, 339, 4204, -3068, -6193, 10655, 23843
	};

	sample_t    hist [45];       // delay line, newest at the top
	sample_t    word_q [$];      // words waiting to be offered
	filt_word_t filtered_q [$];  // expected filter outputs, oldest first
	int         words_in;
	int         words_out;
	int         err_count;
	int         cycles;
	logic       in_took;
	int         burst_left;
	int         gap_left;
	int         hold_left;
	logic       held_once;
	int         stall_pct;
	int         phase_cnt;

	fir_filter_45_tap_fixed DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.saturated (saturated)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int tap_coef(int k);
		return (k <= 22) ? half_coef[k] : half_coef[44 - k];
	endfunction

	// Shift one word in, sum the taps, round to Q1.15 and clip
	function automatic filt_word_t filter_word(sample_t x);
		longint     acc;
		longint     q;
		filt_word_t w;
		for (int k = 0; k < 44; k++)
			hist[k] = hist[k + 1];
		hist[44] = x;
		acc = 0;
		for (int k = 0; k < 45; k++)
			acc += longint'(hist[k]) * longint'(tap_coef(k));
		q = (acc + 64'sd8192) >>> 14;
		w.clipped = 1'b0;
		if (q > 32767) begin
			q = 32767;
			w.clipped = 1'b1;
		end else if (q < -32768) begin
			q = -32768;
			w.clipped = 1'b1;
		end
		w.value = sample_t'(q);
		return w;
	endfunction

	// Build the word list: impulse, extremes, then mixed random traffic
	task automatic fill_words();
		int mode;
		int pol;
		int mag;
		int v;
		word_q.push_back(sample_t'(32767));
		repeat (22) word_q.push_back(sample_t'(0));
		word_q.push_back(sample_t'(-32768));
		word_q.push_back(sample_t'(-1));
		while (word_q.size() < N_RANDOM + 25) begin
			mode = $urandom_range(0, 99);
			if (mode < 60) begin
				word_q.push_back(sample_t'($urandom_range(0, 65535)));
			end else if (mode < 75) begin
				word_q.push_back(sample_t'(int'($urandom_range(0, 512)) - 256));
			end else if (mode < 85) begin
				case ($urandom_range(0, 4))
					0: word_q.push_back(sample_t'(32767));
					1: word_q.push_back(sample_t'(-32768));
					2: word_q.push_back(sample_t'(-1));
					3: word_q.push_back(sample_t'(1));
					default: word_q.push_back(sample_t'(0));
				endcase
			end else begin
				// sign-matched run of 45 words drives the sum past full scale
				pol = ($urandom_range(0, 1) == 0) ? 1 : -1;
				for (int j = 0; j < 45; j++) begin
					mag = $urandom_range(20000, 32768);
					v = pol * ((tap_coef(j) < 0) ? -mag : mag);
					if (v > 32767)
						v = 32767;
					word_q.push_back(sample_t'(v));
				end
			end
		end
	endtask

	// Sender: bursts of random length with random gaps, plus one drain pause
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (word_q.size() == 0 ||
				             (words_in == DRAIN_AT && filtered_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid  <= 1'b1;
					sample_in <= word_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Receiver: stall rate changes by phase; one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (phase_cnt == 0) begin
				case ($urandom_range(0, 5))
					0, 1: stall_pct <= 0;
					2: stall_pct <= 25;
					3: stall_pct <= 50;
					4: stall_pct <= 75;
					default: stall_pct <= 90;
				endcase
				phase_cnt <= $urandom_range(20, 80);
			end else begin
				phase_cnt <= phase_cnt - 1;
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!held_once && words_in >= HOLDOFF_AT) begin
				held_once <= 1'b1;
				hold_left <= HOLDOFF_LEN;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Monitor: check taken outputs, then predict for taken inputs
	always @(posedge clk) begin
		filt_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$error("output word with nothing expected: sample_out=%0d saturated=%0b",
					       sample_out, saturated);
					err_count = err_count + 1;
				end else begin
					want = filtered_q.pop_front();
					if (sample_out !== want.value) begin
						$error("word %0d sample_out: expected %0d, got %0d",
						       words_out, want.value, sample_out);
						err_count = err_count + 1;
					end
					if (saturated !== want.clipped) begin
						$error("word %0d saturated: expected %0b, got %0b",
						       words_out, want.clipped, saturated);
						err_count = err_count + 1;
					end
				end
				words_out <= words_out + 1;
			end
			if (in_valid && !in_stall) begin
				filtered_q.push_back(filter_word(sample_in));
				words_in <= words_in + 1;
			end
			in_took <= in_valid && !in_stall;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d words still expected",
			       cycles, filtered_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample_in  = '0;
		out_stall  = 1'b0;
		in_took    = 1'b0;
		words_in   = 0;
		words_out  = 0;
		err_count  = 0;
		cycles     = 0;
		burst_left = 0;
		gap_left   = 0;
		hold_left  = 0;
		held_once  = 1'b0;
		stall_pct  = 0;
		phase_cnt  = 0;
		for (int k = 0; k < 45; k++)
			hist[k] = '0;
		fill_words();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		wait (word_q.size() == 0 && !in_valid);
		wait (filtered_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
